@@ rtl/sat_pkg.sv @@
package sat_pkg;

	// Default table depth
	localparam int MAX_SECTIONS_DEF = 16;

	// Request kinds carried in the input tuser
	localparam logic [2:0] RQ_LOAD    = 3'd0;
	localparam logic [2:0] RQ_RVA2OFF = 3'd1;
	localparam logic [2:0] RQ_OFF2RVA = 3'd2;
	localparam logic [2:0] RQ_LOCATE  = 3'd3;
	localparam logic [2:0] RQ_VA2OFF  = 3'd4;
	localparam logic [2:0] RQ_OFF2VA  = 3'd5;

	// Result status carried in the output tuser
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_LOADED   = 2'd2;

	// Configuration register indexes (paddr[2])
	localparam logic REG_SECTION_COUNT = 1'b0;
	localparam logic REG_IMAGE_BASE    = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_CHK0,
		S_SCAN,
		S_ADJ
	} sat_state_t;

	// One section table entry, as stored in the RAM
	typedef struct packed {
		logic [31:0] raw_size;
		logic [31:0] raw_start;
		logic [31:0] virt_size;
		logic [31:0] virt_start;
	} sat_entry_t;

	// Range unit result
	typedef struct packed {
		logic        below;
		logic        hit;
		logic [31:0] mapped;
	} sat_cmp_t;

endpackage

@@ rtl/sat_ram.sv @@
module sat_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sat_range_unit.sv @@
module sat_range_unit (
	input  logic [31:0]       q,
	input  logic [31:0]       start,
	input  logic [31:0]       size,
	input  logic [31:0]       target,
	output sat_pkg::sat_cmp_t res
);
	import sat_pkg::*;

	logic [32:0] range_end;

	// End computed in 33 bits so it never wraps
	assign range_end  = {1'b0, start} + {1'b0, size};
	assign res.below  = (q < start);
	assign res.hit    = !res.below && ({1'b0, q} < range_end);
	// Rebase: q - start + target, modulo 2^32
	assign res.mapped = q - start + target;

endmodule

@@ rtl/section_address_translator.sv @@
// Section address translator.
// Input stream (s_axis_*): one beat per request. tuser is the request kind:
// load a table entry, or translate query_value (rva->offset, offset->rva,
// locate rva, va->offset, offset->va). Output stream (m_axis_*): exactly one
// beat per input beat, in order, tuser is the status.
// APB port: section_count at 0x0, image_base at 0x4; write only while idle.
// Timing: a load or an unknown request is answered in the cycle after it is
// taken. A query walks the table one entry per cycle through a single range
// compare unit fed by a registered-read RAM with separate write and read
// ports: entry 0 is read (S_HDR), the header region below it is checked
// (S_CHK0), then entries are scanned in order (S_SCAN), and offset->va adds
// an S_ADJ step (image base added by the same unit). Only one request is in
// flight at a time; the next beat can be taken at the edge that takes the
// result, so a new request waits until the last result has been written.
// The result sits in an output register; s_axis_tready is high only while
// the sequencer is idle and that register is empty or being drained, so a
// stalled receiver holds back the input.
// Reset clears the sequencer, the output valid, section_count to 1 and
// image_base to 0. The table itself is not cleared: load entries first.
module section_address_translator #(
	parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// entry_index[3:0], virt_start[35:4], virt_size[67:36], raw_start[99:68],
	// raw_size[131:100], query_value[163:132], zero[167:164]
	input  logic [167:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]   s_axis_tuser,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mapped_value[31:0], section_number[36:32], zero[39:37]
	output logic [39:0]  m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import sat_pkg::*;

	localparam int AW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	// Input beat fields
	logic [2:0]  in_req;
	logic [3:0]  in_idx;
	logic [31:0] in_query;
	sat_entry_t  in_entry;

	assign in_req              = s_axis_tuser;
	assign in_idx              = s_axis_tdata[3:0];
	assign in_entry.virt_start = s_axis_tdata[35:4];
	assign in_entry.virt_size  = s_axis_tdata[67:36];
	assign in_entry.raw_start  = s_axis_tdata[99:68];
	assign in_entry.raw_size   = s_axis_tdata[131:100];
	assign in_query            = s_axis_tdata[163:132];

	// Configuration registers
	logic [4:0]  section_count_q;
	logic [31:0] image_base_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= 5'd1;
			image_base_q    <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_SECTION_COUNT) begin
				section_count_q <= pwdata[4:0];
			end else begin
				image_base_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_IMAGE_BASE) ? image_base_q : {27'd0, section_count_q};

	// Sequencer and datapath registers
	sat_state_t       state_q, state_d;
	logic [2:0]       req_q;
	logic [31:0]      q_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] nxt_i;
	logic [31:0]      res_val_q;
	logic [4:0]       res_sec_q;
	logic             out_valid_q;
	logic [31:0]      out_val_q;
	logic [4:0]       out_sec_q;
	logic [1:0]       out_st_q;

	// Control from the next-state logic
	logic             s_acc;
	logic             from_raw;
	logic             q_we;
	logic             scan_step;
	logic             res_we;
	logic [31:0]      res_val_d;
	logic [4:0]       res_sec_d;
	logic             out_we;
	logic [31:0]      out_val_d;
	logic [4:0]       out_sec_d;
	logic [1:0]       out_st_d;

	// Effective search count, min(section_count, MAX_SECTIONS)
	logic [31:0]      cnt_ext;
	logic [31:0]      n_ext;
	assign cnt_ext = {27'd0, section_count_q};
	assign n_ext   = (cnt_ext > 32'(MAX_SECTIONS)) ? 32'(MAX_SECTIONS) : cnt_ext;

	// Table RAM
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [31:0]      idx_ext;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [$bits(sat_entry_t)-1:0] ram_rdata;
	sat_entry_t       ent;

	assign idx_ext   = {28'd0, in_idx};
	assign ram_waddr = idx_ext[AW-1:0];
	assign ram_we    = s_acc && (in_req == RQ_LOAD) && (idx_ext < 32'(MAX_SECTIONS));
	assign ent       = sat_entry_t'(ram_rdata);

	sat_ram #(
		.WIDTH ($bits(sat_entry_t)),
		.DEPTH (MAX_SECTIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared range/rebase unit
	logic [31:0] u_q, u_start, u_size, u_target;
	sat_cmp_t    u_res;

	sat_range_unit u_unit (
		.q      (u_q),
		.start  (u_start),
		.size   (u_size),
		.target (u_target),
		.res    (u_res)
	);

	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign from_raw      = (req_q == RQ_OFF2RVA) || (req_q == RQ_OFF2VA);
	assign nxt_i         = i_q + CNT_W'(1);

	// Next state, unit operands, result selection
	always_comb begin
		state_d   = state_q;
		q_we      = 1'b0;
		scan_step = 1'b0;
		res_we    = 1'b0;
		res_val_d = u_res.mapped;
		res_sec_d = 5'd0;
		out_we    = 1'b0;
		out_val_d = '0;
		out_sec_d = '0;
		out_st_d  = ST_NOTFOUND;
		ram_re    = 1'b0;
		ram_raddr = '0;
		u_q       = q_q;
		u_start   = from_raw ? ent.raw_start : ent.virt_start;
		u_size    = from_raw ? ent.raw_size : ent.virt_size;
		u_target  = from_raw ? ent.virt_start : ent.raw_start;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					if (in_req == RQ_LOAD) begin
						out_we   = 1'b1;
						out_st_d = ST_LOADED;
					end else if (in_req == RQ_RVA2OFF || in_req == RQ_OFF2RVA ||
							in_req == RQ_LOCATE || in_req == RQ_VA2OFF ||
							in_req == RQ_OFF2VA) begin
						state_d = S_HDR;
					end else begin
						out_we = 1'b1;
					end
				end
			end
			S_HDR: begin
				// Fetch entry 0; rebase va queries by the image base
				ram_re    = 1'b1;
				ram_raddr = '0;
				q_we      = 1'b1;
				u_start   = (req_q == RQ_VA2OFF) ? image_base_q : 32'd0;
				u_size    = '0;
				u_target  = '0;
				state_d   = S_CHK0;
			end
			S_CHK0: begin
				// Header region check against entry 0
				if (u_res.below) begin
					if (req_q == RQ_OFF2VA) begin
						res_we    = 1'b1;
						res_val_d = q_q;
						state_d   = S_ADJ;
					end else begin
						out_we    = 1'b1;
						out_val_d = (req_q == RQ_LOCATE) ? 32'd0 : q_q;
						out_st_d  = ST_OK;
						state_d   = S_IDLE;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// One entry per cycle, first match wins
				if (i_q >= n_q) begin
					out_we  = 1'b1;
					state_d = S_IDLE;
				end else if (u_res.hit) begin
					res_sec_d = 5'({{(32-CNT_W){1'b0}}, i_q} + 32'd1);
					if (req_q == RQ_OFF2VA) begin
						res_we  = 1'b1;
						state_d = S_ADJ;
					end else begin
						out_we    = 1'b1;
						out_val_d = (req_q == RQ_LOCATE) ? 32'd0 : u_res.mapped;
						out_sec_d = res_sec_d;
						out_st_d  = ST_OK;
						state_d   = S_IDLE;
					end
				end else begin
					scan_step = 1'b1;
					ram_re    = (nxt_i < n_q);
					ram_raddr = nxt_i[AW-1:0];
				end
			end
			S_ADJ: begin
				// Add the image base to the file-to-va result
				u_q       = res_val_q;
				u_start   = '0;
				u_size    = '0;
				u_target  = image_base_q;
				out_we    = 1'b1;
				out_val_d = u_res.mapped;
				out_sec_d = res_sec_q;
				out_st_d  = ST_OK;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_we) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_q <= in_req;
			q_q   <= in_query;
			n_q   <= n_ext[CNT_W-1:0];
			i_q   <= '0;
		end else begin
			if (q_we) begin
				q_q <= u_res.mapped;
			end
			if (scan_step) begin
				i_q <= nxt_i;
			end
		end
		if (res_we) begin
			res_val_q <= res_val_d;
			res_sec_q <= res_sec_d;
		end
		if (out_we) begin
			out_val_q <= out_val_d;
			out_sec_q <= out_sec_d;
			out_st_q  <= out_st_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_sec_q, out_val_q};
	assign m_axis_tuser  = out_st_q;

	// A result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_we |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten");

	// Input is taken only by the idle sequencer
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");

	// Scan index never passes the search count
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (i_q <= n_q))
		else $error("scan index beyond count");

	// A query in flight ends in exactly one result
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_d == S_IDLE) |-> out_we)
		else $error("query finished without a result");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import sat_pkg::*;

	localparam int         SLOT_COUNT    = MAX_SECTIONS_DEF;
	localparam int         IDLE_LIMIT    = 3000;
	// req_type values outside the defined set
	localparam logic [2:0] RQ_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] RQ_UNKNOWN_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] virt_start;
		logic [31:0] virt_size;
		logic [31:0] raw_start;
		logic [31:0] raw_size;
		logic [31:0] query;
	} xlate_req_t;

	typedef struct packed {
		logic [31:0] mapped;
		logic [4:0]  section;
		logic [1:0]  status;
	} xlate_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [167:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = RQ_LOAD;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// Shadow copy of the section table and registers
	logic [31:0] tbl_vstart [SLOT_COUNT];
	logic [31:0] tbl_vsize  [SLOT_COUNT];
	logic [31:0] tbl_rstart [SLOT_COUNT];
	logic [31:0] tbl_rsize  [SLOT_COUNT];
	logic [4:0]  cfg_count = 5'd1;
	logic [31:0] cfg_base = '0;

	xlate_result_t expected_results [$];
	xlate_result_t due_result;
	int            mismatch_count = 0;
	int            idle_cycles = 0;
	int            send_burst_left = 0;
	int            sink_hold = 0;
	int            sink_roll;

	section_address_translator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// First-match walk over the active entries; header region is below entry 0
	function automatic bit find_section(input logic [31:0] q, input bit from_raw,
			output logic [31:0] val, output logic [4:0] sec);
		int          n;
		logic [31:0] s, z, t;
		logic [32:0] range_end;
		val = '0;
		sec = '0;
		n = (cfg_count > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_count);
		if (q < (from_raw ? tbl_rstart[0] : tbl_vstart[0])) begin
			val = q;
			return 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			s = from_raw ? tbl_rstart[i] : tbl_vstart[i];
			z = from_raw ? tbl_rsize[i] : tbl_vsize[i];
			t = from_raw ? tbl_vstart[i] : tbl_rstart[i];
			range_end = {1'b0, s} + {1'b0, z};
			if (q >= s && {1'b0, q} < range_end) begin
				val = q - s + t;
				sec = 5'(i + 1);
				return 1'b1;
			end
		end
		val = '0;
		return 1'b0;
	endfunction

	// Result of one request; a load also updates the shadow table
	function automatic xlate_result_t predict_translation(input xlate_req_t r);
		xlate_result_t res;
		logic [31:0]   q, val;
		logic [4:0]    sec;
		res = '{mapped: '0, section: '0, status: ST_NOTFOUND};
		case (r.kind)
			RQ_LOAD: begin
				tbl_vstart[r.slot] = r.virt_start;
				tbl_vsize[r.slot]  = r.virt_size;
				tbl_rstart[r.slot] = r.raw_start;
				tbl_rsize[r.slot]  = r.raw_size;
				res.status = ST_LOADED;
			end
			RQ_RVA2OFF, RQ_OFF2RVA, RQ_LOCATE, RQ_VA2OFF, RQ_OFF2VA: begin
				q = (r.kind == RQ_VA2OFF) ? r.query - cfg_base : r.query;
				if (find_section(q, r.kind == RQ_OFF2RVA || r.kind == RQ_OFF2VA, val, sec)) begin
					res.status  = ST_OK;
					res.section = sec;
					if (r.kind == RQ_LOCATE)
						res.mapped = '0;
					else if (r.kind == RQ_OFF2VA)
						res.mapped = val + cfg_base;
					else
						res.mapped = val;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic xlate_req_t make_load(input logic [3:0] slot, input logic [31:0] vs,
			input logic [31:0] vz, input logic [31:0] rs, input logic [31:0] rz);
		xlate_req_t r;
		r = '0;
		r.kind       = RQ_LOAD;
		r.slot       = slot;
		r.virt_start = vs;
		r.virt_size  = vz;
		r.raw_start  = rs;
		r.raw_size   = rz;
		return r;
	endfunction

	function automatic xlate_req_t make_query(input logic [2:0] kind, input logic [31:0] q);
		xlate_req_t r;
		r = '0;
		r.kind  = kind;
		r.query = q;
		return r;
	endfunction

	// Mostly small well-formed sections, some fully random, some near the top
	function automatic xlate_req_t with_random_section(input xlate_req_t r);
		int roll;
		roll = $urandom_range(99);
		if (roll < 65) begin
			r.virt_start = $urandom_range(32'h00FF_FFFF) & 32'hFFFF_F000;
			r.virt_size  = $urandom_range(32'h0002_0000);
			r.raw_start  = $urandom_range(32'h00FF_FFFF) & 32'hFFFF_FE00;
			r.raw_size   = $urandom_range(32'h0002_0000);
		end else if (roll < 90) begin
			r.virt_start = $urandom;
			r.virt_size  = $urandom;
			r.raw_start  = $urandom;
			r.raw_size   = $urandom;
		end else begin
			r.virt_start = 32'hFFFF_0000 | $urandom_range(32'hFFFF);
			r.virt_size  = $urandom;
			r.raw_start  = 32'hFFFF_0000 | $urandom_range(32'hFFFF);
			r.raw_size   = $urandom;
		end
		return r;
	endfunction

	// Query value aimed at an entry: inside, on its edges, or anywhere
	function automatic logic [31:0] pick_query(input bit from_raw);
		int          n, e;
		logic [31:0] s, z;
		n = (cfg_count == 0) ? 1 : ((cfg_count > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_count));
		e = ($urandom_range(9) == 0) ? $urandom_range(SLOT_COUNT - 1) : $urandom_range(n - 1);
		s = from_raw ? tbl_rstart[e] : tbl_vstart[e];
		z = from_raw ? tbl_rsize[e] : tbl_vsize[e];
		case ($urandom_range(9))
			0: return $urandom;
			1: return s - 1;
			2: return s;
			3: return s + z - 1;
			4: return s + z;
			default: return s + ((z == 0) ? 32'd0 : ($urandom % z));
		endcase
	endfunction

	function automatic int pick_send_gap();
		int roll;
		if (send_burst_left > 0) begin
			send_burst_left--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 3)
			send_burst_left = $urandom_range(20, 80);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endtask

	// Send one beat; valid stays high afterwards unless the next beat idles first
	task automatic send_item(input xlate_req_t r);
		int gap;
		gap = pick_send_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.kind;
		s_axis_tdata  <= {4'b0000, r.query, r.raw_size, r.raw_start, r.virt_size,
			r.virt_start, r.slot};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.push_back(predict_translation(r));
	endtask

	task automatic wait_until_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write a register, then read it back; block must be idle
	task automatic program_register(input logic sel, input logic [31:0] value);
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_SECTION_COUNT) begin
			cfg_count = value[4:0];
			want = {27'd0, value[4:0]};
		end else begin
			cfg_base = value;
			want = value;
		end
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			flag_mismatch("register readback", want, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [31:0] count, input logic [31:0] base);
		wait_until_idle();
		program_register(REG_SECTION_COUNT, count);
		program_register(REG_IMAGE_BASE, base);
	endtask

	// Hand-built table: empty virtual range, a section ending past 2^32
	task automatic test_directed_translation();
		apply_config(4, 32'h0040_0000);
		send_item(make_load(4'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0400, 32'h0000_1800));
		send_item(make_load(4'd1, 32'h0000_3000, 32'h0000_0000, 32'h0000_1C00, 32'h0000_0200));
		send_item(make_load(4'd2, 32'h0000_5000, 32'h0000_1000, 32'h0000_2000, 32'h0000_1000));
		send_item(make_load(4'd3, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_0000));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_0FFF));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_1000));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_2FFF));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_3000));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_5800));
		send_item(make_query(RQ_RVA2OFF, 32'hFFFF_FFFF));
		send_item(make_query(RQ_OFF2RVA, 32'h0000_03FF));
		send_item(make_query(RQ_OFF2RVA, 32'h0000_1C00));
		send_item(make_query(RQ_LOCATE, 32'h0000_5000));
		send_item(make_query(RQ_LOCATE, 32'h0000_4000));
		send_item(make_query(RQ_VA2OFF, 32'h0040_1000));
		send_item(make_query(RQ_VA2OFF, 32'h0000_0000));
		send_item(make_query(RQ_OFF2VA, 32'h0000_2100));
		send_item(make_query(RQ_OFF2VA, 32'hFFFF_FFFF));
		send_item(make_query(RQ_UNKNOWN_LO, 32'h0000_1000));
		send_item(make_query(RQ_UNKNOWN_HI, 32'hFFFF_FFFF));
	endtask

	// Fill the rest of the slots so every entry is defined from here on
	task automatic test_table_fill();
		for (int i = 4; i < SLOT_COUNT; i++)
			send_item(with_random_section(make_load(4'(i), '0, '0, '0, '0)));
	endtask

	// Zero count, count past the table depth, image base extremes
	task automatic test_count_limits();
		apply_config(0, 32'h0040_0000);
		send_item(make_query(RQ_RVA2OFF, 32'h0000_0800));
		send_item(make_query(RQ_RVA2OFF, 32'h0000_1800));
		send_item(make_query(RQ_OFF2RVA, 32'h0000_0500));
		apply_config(31, 32'h0040_0000);
		send_item(make_query(RQ_RVA2OFF, 32'h7FFF_FFFF));
		send_item(make_query(RQ_OFF2RVA, tbl_rstart[15]));
		send_item(make_query(RQ_LOCATE, tbl_vstart[15]));
		apply_config(16, 32'hFFFF_FFFF);
		send_item(make_query(RQ_VA2OFF, 32'h0000_0FFF));
		send_item(make_query(RQ_OFF2VA, 32'h0000_0400));
		apply_config(1, 32'h0000_0000);
		send_item(make_query(RQ_VA2OFF, 32'h0000_1000));
		send_item(make_query(RQ_OFF2VA, 32'h0000_0400));
	endtask

	task automatic send_random_item();
		xlate_req_t r;
		int         roll;
		r.slot       = 4'($urandom_range(SLOT_COUNT - 1));
		r.virt_start = $urandom;
		r.virt_size  = $urandom;
		r.raw_start  = $urandom;
		r.raw_size   = $urandom;
		r.query      = $urandom;
		roll = $urandom_range(99);
		if (roll < 12) begin
			r.kind = RQ_LOAD;
			r = with_random_section(r);
		end else if (roll < 16) begin
			r.kind = ($urandom_range(1) == 0) ? RQ_UNKNOWN_LO : RQ_UNKNOWN_HI;
		end else begin
			case ($urandom_range(4))
				0: r.kind = RQ_RVA2OFF;
				1: r.kind = RQ_OFF2RVA;
				2: r.kind = RQ_LOCATE;
				3: r.kind = RQ_VA2OFF;
				default: r.kind = RQ_OFF2VA;
			endcase
			r.query = pick_query(r.kind == RQ_OFF2RVA || r.kind == RQ_OFF2VA);
			if (r.kind == RQ_VA2OFF)
				r.query = r.query + cfg_base;
		end
		send_item(r);
	endtask

	// Phases of random traffic, each under a fresh register setting
	task automatic test_random_traffic();
		logic [31:0] count, base;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(9))
				0: count = 0;
				1: count = $urandom_range(17, 31);
				2: count = SLOT_COUNT;
				3: count = 1;
				default: count = $urandom_range(1, SLOT_COUNT);
			endcase
			case ($urandom_range(3))
				0: base = 32'h0000_0000;
				1: base = 32'hFFFF_FFFF;
				default: base = $urandom;
			endcase
			apply_config(count, base);
			repeat (400) send_random_item();
		end
	endtask

	// Receiver: short and long stalls, plus stretches always ready
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else begin
			sink_roll = $urandom_range(99);
			if (sink_roll < 50) begin
				m_axis_tready <= 1'b1;
				sink_hold <= $urandom_range(8);
			end else if (sink_roll < 57) begin
				m_axis_tready <= 1'b1;
				sink_hold <= $urandom_range(30, 120);
			end else if (sink_roll < 92) begin
				m_axis_tready <= 1'b0;
				sink_hold <= $urandom_range(3);
			end else begin
				m_axis_tready <= 1'b0;
				sink_hold <= $urandom_range(10, 50);
			end
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected result beat", '0, m_axis_tdata[31:0]);
			end else begin
				due_result = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== due_result.mapped)
					flag_mismatch("mapped_value", due_result.mapped, m_axis_tdata[31:0]);
				if (m_axis_tdata[36:32] !== due_result.section)
					flag_mismatch("section_number", 32'(due_result.section),
						32'(m_axis_tdata[36:32]));
				if (m_axis_tuser !== due_result.status)
					flag_mismatch("status", 32'(due_result.status), 32'(m_axis_tuser));
			end
		end
	end

	// Watchdog on cycles with no beat and no register access
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("section_address_translator regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_translation();
		test_table_fill();
		test_count_limits();
		test_random_traffic();
		wait_until_idle();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("section_address_translator regression: pass");
		else
			$display("section_address_translator regression: fail");
		$finish;
	end

endmodule
